// File: hdl/set_assoc_cache_lru_lfu_assert.svh
// Assertion macros shared by the cache directory RTL.
`ifndef SET_ASSOC_CACHE_LRU_LFU_ASSERT_SVH
`define SET_ASSOC_CACHE_LRU_LFU_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SACL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SACL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/sacl_pkg.sv
// Shared types and constants of the set-associative cache directory.
package sacl_pkg;

    // Default sizing
    localparam int DEF_MAX_INDEX_BITS = 8;
    localparam int DEF_MAX_WAYS       = 8;
    localparam int DEF_ADDR_WIDTH     = 32;

    // Stored tag and counter widths
    localparam int TAG_W   = 32;
    localparam int COUNT_W = 32;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_INDEX_BITS  = 3'd0,
        CFG_OFFSET_BITS = 3'd1,
        CFG_ADDR_BITS   = 3'd2,
        CFG_WAYS_USED   = 3'd3,
        CFG_HIT_CYCLES  = 3'd4,
        CFG_MISS_EXTRA  = 3'd5,
        CFG_POLICY      = 3'd6
    } cfg_reg_t;

    // Result transaction: hit, way, replaced_valid, cycle_total, miss_total
    localparam int OUT_FIELDS_W = 1 + 3 + 1 + COUNT_W + COUNT_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    // One line of a set as held in the directory memory
    typedef struct packed {
        logic               valid;
        logic [TAG_W-1:0]   tag;
        logic [COUNT_W-1:0] hits;
        logic [COUNT_W-1:0] stamp;
    } line_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_UPD
    } state_t;

endpackage

// File: hdl/sacl_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module sacl_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/set_assoc_cache_lru_lfu.sv
// Top level of the set-associative cache directory with LRU or LFU replacement.
//
// Each input transaction carries one byte address; the block looks it up in a
// directory of 2**MAX_INDEX_BITS sets of MAX_WAYS lines and returns one result
// transaction with hit, way, replaced_valid and the running cycle and miss
// totals. All lines of a set sit in one row of a single directory memory, so a
// lookup is: issue the row read on acceptance, compare tags and rank the ways
// (ST_LOOK), then pick the way, update the line and write the row back
// (ST_UPD). ST_UPD also accepts the next address unless the output register
// is still full and not taken, so a new lookup can start while the last one is
// written back; a row read that meets the row just written takes the written
// data through a forwarding register. The result is registered as the row is
// written back and sits in an output register until taken. After reset the
// block clears the valid bits with a pass over all rows of the memory and
// accepts no address until it ends; configuration writes are taken at any time.
`include "set_assoc_cache_lru_lfu_assert.svh"

module set_assoc_cache_lru_lfu
    import sacl_pkg::*;
#(
    parameter int MAX_INDEX_BITS = DEF_MAX_INDEX_BITS,
    parameter int MAX_WAYS       = DEF_MAX_WAYS,
    parameter int ADDR_WIDTH     = DEF_ADDR_WIDTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration write port
    input  logic                                cfg_we,
    input  logic [CFG_ADDR_W-1:0]               cfg_addr,
    input  logic [CFG_DATA_W-1:0]               cfg_wdata,
    // Address stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [((ADDR_WIDTH+7)/8)*8-1:0]     s_axis_tdata,  // address
    // Result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [OUT_DATA_W-1:0]               m_axis_tdata   // hit, way[3], replaced_valid,
                                                               // cycle_total[32], miss_total[32]
);

    localparam int SET_AW = (MAX_INDEX_BITS > 0) ? MAX_INDEX_BITS : 1;
    localparam int SETS   = 1 << MAX_INDEX_BITS;
    localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int ROW_W  = MAX_WAYS * $bits(line_t);

    // Configuration registers
    logic [3:0]  index_bits_reg;
    logic [4:0]  offset_bits_reg;
    logic [5:0]  address_bits_reg;
    logic [3:0]  ways_used_reg;
    logic [15:0] hit_cycles_reg;
    logic [15:0] miss_extra_reg;
    logic        policy_reg;

    // Control and datapath state
    state_t                    state_reg, state_next;
    logic [SET_AW:0]           clr_cnt_reg;
    logic                      clearing;
    logic [SET_AW-1:0]         set_reg;
    logic [TAG_W-1:0]          tag_reg;
    line_t [MAX_WAYS-1:0]      row_reg;
    logic [MAX_WAYS-1:0]       hitv_reg, invv_reg, vict_reg;
    logic [MAX_WAYS-1:0]       hitv_next, invv_next, vict_next;
    logic                      fwd_vld_reg;
    logic [SET_AW-1:0]         fwd_set_reg;
    line_t [MAX_WAYS-1:0]      fwd_row_reg;
    logic [COUNT_W-1:0]        cycle_sum_reg, cycle_sum_next;
    logic [COUNT_W-1:0]        miss_sum_reg, miss_sum_next;
    logic                      m_valid_reg;
    logic [OUT_DATA_W-1:0]     m_data_reg;

    // Handshake and memory interface
    logic                      accept;
    logic                      upd_go;
    logic                      upd_fire;
    logic                      ram_we;
    logic [SET_AW-1:0]         ram_waddr;
    logic [ROW_W-1:0]          ram_wdata;
    logic [ROW_W-1:0]          ram_rdata;
    line_t [MAX_WAYS-1:0]      rd_row;
    line_t [MAX_WAYS-1:0]      row_cur;
    line_t [MAX_WAYS-1:0]      row_new;

    // Address split
    logic [ADDR_WIDTH-1:0]     addr;
    logic [3:0]                ib;
    logic [6:0]                ab;
    logic [5:0]                used_bits;
    logic [6:0]                tw;
    logic [4:0]                nw;
    logic [SET_AW:0]           set_mask;
    logic [TAG_W-1:0]          tag_mask;
    logic [SET_AW-1:0]         set_in;
    logic [TAG_W-1:0]          tag_in;
    logic [MAX_WAYS-1:0]       way_en;

    // Update stage
    logic                      hit;
    logic                      free;
    logic                      replaced;
    logic [WAY_W-1:0]          sel_way;
    line_t                     line_old, line_new;
    logic [COUNT_W-1:0]        key [MAX_WAYS];

    function automatic logic [WAY_W-1:0] lowest(input logic [MAX_WAYS-1:0] v);
        logic [WAY_W-1:0] idx;
        idx = '0;
        for (int i = MAX_WAYS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = WAY_W'(i);
            end
        end
        return idx;
    endfunction

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_bits_reg   <= 4'd0;
            offset_bits_reg  <= 5'd0;
            address_bits_reg <= 6'd32;
            ways_used_reg    <= 4'd1;
            hit_cycles_reg   <= 16'd1;
            miss_extra_reg   <= 16'd0;
            policy_reg       <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_INDEX_BITS:  index_bits_reg   <= cfg_wdata[3:0];
                CFG_OFFSET_BITS: offset_bits_reg  <= cfg_wdata[4:0];
                CFG_ADDR_BITS:   address_bits_reg <= cfg_wdata[5:0];
                CFG_WAYS_USED:   ways_used_reg    <= cfg_wdata[3:0];
                CFG_HIT_CYCLES:  hit_cycles_reg   <= cfg_wdata;
                CFG_MISS_EXTRA:  miss_extra_reg   <= cfg_wdata;
                CFG_POLICY:      policy_reg       <= cfg_wdata[0];
                default:         ;
            endcase
        end
    end

    // Clamp the configuration and split the incoming address
    always_comb
    begin
        addr      = s_axis_tdata[ADDR_WIDTH-1:0];
        ib        = (index_bits_reg > 4'(MAX_INDEX_BITS)) ? 4'(MAX_INDEX_BITS)
                                                          : index_bits_reg;
        ab        = ({1'b0, address_bits_reg} > 7'(ADDR_WIDTH)) ? 7'(ADDR_WIDTH)
                                                                 : {1'b0, address_bits_reg};
        used_bits = 6'(offset_bits_reg) + 6'(ib);
        tw        = (ab > 7'(used_bits)) ? ab - 7'(used_bits) : 7'd0;
        if (ways_used_reg == 4'd0)
            nw = 5'd1;
        else if ({1'b0, ways_used_reg} > 5'(MAX_WAYS))
            nw = 5'(MAX_WAYS);
        else
            nw = {1'b0, ways_used_reg};
        set_mask = ((SET_AW+1)'(1) << ib) - (SET_AW+1)'(1);
        tag_mask = (tw >= 7'(TAG_W)) ? '1 : ((TAG_W'(1) << tw) - TAG_W'(1));
        set_in   = SET_AW'(addr >> offset_bits_reg) & set_mask[SET_AW-1:0];
        tag_in   = TAG_W'(addr >> used_bits) & tag_mask;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            way_en[w] = (5'(w) < nw);
        end
    end

    // Clearing pass over the directory after reset
    assign clearing = (clr_cnt_reg != (SET_AW+1)'(SETS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_cnt_reg <= '0;
        else if (clearing)
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
    end

    // Sequencer: next state and handshakes
    always_comb
    begin
        state_next    = state_reg;
        upd_go        = !m_valid_reg || m_axis_tready;
        s_axis_tready = 1'b0;
        upd_fire      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = !clearing;
            end
            ST_LOOK:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                upd_fire      = upd_go;
                s_axis_tready = upd_go;
                if (upd_go)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        accept = s_axis_tvalid && s_axis_tready;
        if (accept)
            state_next = ST_LOOK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Lookup registers taken at acceptance
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            set_reg <= set_in;
            tag_reg <= tag_in;
        end
    end

    // Directory memory: one row per set
    assign ram_we    = clearing || upd_fire;
    assign ram_waddr = clearing ? clr_cnt_reg[SET_AW-1:0] : set_reg;
    assign ram_wdata = clearing ? '0 : row_new;

    sacl_ram #(
        .WIDTH  (ROW_W),
        .DEPTH  (SETS),
        .ADDR_W (SET_AW)
    ) u_dir_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (set_in),
        .rdata (ram_rdata)
    );

    assign rd_row = ram_rdata;

    // Compare stage: tag match, free ways and victim ranking
    always_comb
    begin
        row_cur = (fwd_vld_reg && fwd_set_reg == set_reg) ? fwd_row_reg : rd_row;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            key[w] = policy_reg ? row_cur[w].hits : row_cur[w].stamp;
        end
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            hitv_next[w] = way_en[w] && row_cur[w].valid && (row_cur[w].tag == tag_reg);
            invv_next[w] = way_en[w] && !row_cur[w].valid;
            // lowest used way holding the smallest key
            vict_next[w] = way_en[w];
            for (int v = 0; v < MAX_WAYS; v++)
            begin
                if (way_en[v] && v < w && !(key[w] < key[v]))
                    vict_next[w] = 1'b0;
                if (way_en[v] && v > w && (key[v] < key[w]))
                    vict_next[w] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LOOK)
        begin
            row_reg  <= row_cur;
            hitv_reg <= hitv_next;
            invv_reg <= invv_next;
            vict_reg <= vict_next;
        end
    end

    // Update stage: way choice, line update, totals
    always_comb
    begin
        hit      = |hitv_reg;
        free     = |invv_reg;
        replaced = !hit && !free;
        if (hit)
            sel_way = lowest(hitv_reg);
        else if (free)
            sel_way = lowest(invv_reg);
        else
            sel_way = lowest(vict_reg);

        cycle_sum_next = cycle_sum_reg + COUNT_W'(hit_cycles_reg)
                       + (hit ? '0 : COUNT_W'(miss_extra_reg));
        miss_sum_next  = hit ? miss_sum_reg : miss_sum_reg + 1'b1;

        line_old = row_reg[sel_way];
        line_new = line_old;
        if (hit)
        begin
            if (policy_reg)
            begin
                if (line_old.hits != '1)
                    line_new.hits = line_old.hits + 1'b1;
            end
            else
            begin
                line_new.stamp = cycle_sum_next;
            end
        end
        else
        begin
            line_new.valid = 1'b1;
            line_new.tag   = tag_reg;
            line_new.hits  = '0;
            line_new.stamp = policy_reg ? '0 : cycle_sum_next;
        end
        row_new          = row_reg;
        row_new[sel_way] = line_new;
    end

    // Running totals and forwarding of the last written row
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cycle_sum_reg <= '0;
            miss_sum_reg  <= '0;
            fwd_vld_reg   <= 1'b0;
        end
        else if (upd_fire)
        begin
            cycle_sum_reg <= cycle_sum_next;
            miss_sum_reg  <= miss_sum_next;
            fwd_vld_reg   <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd_fire)
        begin
            fwd_set_reg <= set_reg;
            fwd_row_reg <= row_new;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (upd_fire)
            m_valid_reg <= 1'b1;
        else if (m_axis_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (upd_fire)
        begin
            m_data_reg <= OUT_DATA_W'({miss_sum_next, cycle_sum_next, replaced,
                                       3'(sel_way), hit});
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // Checks
    `SACL_ASSERT_NOW(a_hit_not_replaced, clk, rst_n,
        m_axis_tvalid && m_axis_tdata[0], !m_axis_tdata[4],
        "hit transaction reports an eviction")
    `SACL_ASSERT_NOW(a_victim_unique, clk, rst_n,
        state_reg == ST_UPD, $onehot(vict_reg),
        "victim ranking did not select exactly one way")
    `SACL_ASSERT_NEXT(a_update_delivers, clk, rst_n,
        upd_fire, m_axis_tvalid && $past(miss_sum_next) == miss_sum_reg,
        "completed lookup not presented with its miss total")

endmodule

// File: verif/tb.sv
// Self-checking testbench for the set-associative cache directory (LRU/LFU replacement).
`timescale 1ns / 100ps

import sacl_pkg::*;

localparam int DIR_LINES = (1 << DEF_MAX_INDEX_BITS) * DEF_MAX_WAYS;

// One lookup result as the block reports it
typedef struct {
    logic        hit;
    logic [2:0]  way;
    logic        replaced_valid;
    logic [31:0] cycle_total;
    logic [31:0] miss_total;
} lookup_t;

// Directory predictor plus the queue of lookups still owed by the block
class lookup_scoreboard;
    logic [3:0]  index_bits;
    logic [4:0]  offset_bits;
    logic [5:0]  address_bits;
    logic [3:0]  ways_used;
    logic [15:0] hit_cycles;
    logic [15:0] miss_extra;
    logic        lfu;

    bit          line_valid [DIR_LINES];
    logic [31:0] line_tag   [DIR_LINES];
    logic [31:0] line_hits  [DIR_LINES];
    logic [31:0] line_stamp [DIR_LINES];
    logic [31:0] cycle_sum;
    logic [31:0] miss_sum;

    lookup_t     pending_lookups [$];
    int          failures;

    function new();
        index_bits   = 4'd0;
        offset_bits  = 5'd0;
        address_bits = 6'd32;
        ways_used    = 4'd1;
        hit_cycles   = 16'd1;
        miss_extra   = 16'd0;
        lfu          = 1'b0;
        foreach (line_valid[i])
        begin
            line_valid[i] = 1'b0;
            line_tag[i]   = '0;
            line_hits[i]  = '0;
            line_stamp[i] = '0;
        end
        cycle_sum = '0;
        miss_sum  = '0;
        failures  = 0;
    endfunction

    // Registers keep only their low bits; unmapped indexes are dropped
    function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [15:0] val);
        case (idx)
            CFG_INDEX_BITS:  index_bits   = val[3:0];
            CFG_OFFSET_BITS: offset_bits  = val[4:0];
            CFG_ADDR_BITS:   address_bits = val[5:0];
            CFG_WAYS_USED:   ways_used    = val[3:0];
            CFG_HIT_CYCLES:  hit_cycles   = val;
            CFG_MISS_EXTRA:  miss_extra   = val;
            CFG_POLICY:      lfu          = val[0];
            default: ;
        endcase
    endfunction

    function logic [63:0] low_ones(int n);
        return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
    endfunction

    // Look up one address, update the directory and queue the expected result
    function void note_lookup(logic [31:0] address);
        logic [63:0] a;
        int          ib, ab, nw, used, tw, base, w, way;
        logic [31:0] set_no, tag;
        bit          found, free_found, evicted;
        lookup_t     r;

        a    = {32'b0, address};
        ib   = (index_bits > DEF_MAX_INDEX_BITS) ? DEF_MAX_INDEX_BITS : int'(index_bits);
        ab   = (address_bits > DEF_ADDR_WIDTH) ? DEF_ADDR_WIDTH : int'(address_bits);
        nw   = (ways_used == 0) ? 1 :
               ((ways_used > DEF_MAX_WAYS) ? DEF_MAX_WAYS : int'(ways_used));
        used = int'(offset_bits) + ib;
        tw   = (ab > used) ? ab - used : 0;
        set_no = 32'((a >> offset_bits) & low_ones(ib));
        tag    = 32'((a >> used) & low_ones(tw));
        base   = int'(set_no) * DEF_MAX_WAYS;
        found  = 1'b0;
        free_found = 1'b0;
        evicted    = 1'b0;
        way    = 0;

        for (w = 0; w < nw && !found; w++)
        begin
            if (line_valid[base + w] && line_tag[base + w] == tag)
            begin
                found = 1'b1;
                way   = w;
            end
        end

        if (found)
        begin
            cycle_sum = cycle_sum + {16'b0, hit_cycles};
            if (lfu)
            begin
                if (line_hits[base + way] != 32'hFFFF_FFFF)
                    line_hits[base + way] = line_hits[base + way] + 32'd1;
            end
            else
                line_stamp[base + way] = cycle_sum;
        end
        else
        begin
            miss_sum  = miss_sum + 32'd1;
            cycle_sum = cycle_sum + {16'b0, hit_cycles} + {16'b0, miss_extra};
            for (w = 0; w < nw && !free_found; w++)
            begin
                if (!line_valid[base + w])
                begin
                    free_found = 1'b1;
                    way        = w;
                end
            end
            // Full set: oldest stamp or fewest hits, lowest way on a tie
            if (!free_found)
            begin
                way = 0;
                for (w = 1; w < nw; w++)
                begin
                    if (lfu ? (line_hits[base + w] < line_hits[base + way])
                            : (line_stamp[base + w] < line_stamp[base + way]))
                        way = w;
                end
                evicted = 1'b1;
            end
            line_valid[base + way] = 1'b1;
            line_tag[base + way]   = tag;
            line_hits[base + way]  = '0;
            line_stamp[base + way] = lfu ? 32'd0 : cycle_sum;
        end

        r.hit            = found;
        r.way            = way[2:0];
        r.replaced_valid = evicted;
        r.cycle_total    = cycle_sum;
        r.miss_total     = miss_sum;
        pending_lookups.push_back(r);
    endfunction

    function void check_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", field, want, got);
            failures++;
        end
    endfunction

    // Compare one result transaction against the oldest pending lookup
    function void check_result(logic [OUT_DATA_W-1:0] data);
        lookup_t e;
        if (pending_lookups.size() == 0)
        begin
            $error("result with no lookup pending: %h", data);
            failures++;
            return;
        end
        e = pending_lookups.pop_front();
        check_field("hit",            32'(e.hit),            32'(data[0]));
        check_field("way",            32'(e.way),            32'(data[3:1]));
        check_field("replaced_valid", 32'(e.replaced_valid), 32'(data[4]));
        check_field("cycle_total",    e.cycle_total,         data[36:5]);
        check_field("miss_total",     e.miss_total,          data[68:37]);
    endfunction
endclass

module tb;

    localparam int ADDR_DATA_W    = ((DEF_ADDR_WIDTH + 7) / 8) * 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_ITEMS    = 75;
    // Index with no register behind it
    localparam logic [CFG_ADDR_W-1:0] CFG_NO_REG = 3'd7;

    typedef enum {RX_ALWAYS, RX_RANDOM, RX_PERIODIC, RX_SPARSE} rx_pace_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [ADDR_DATA_W-1:0] s_axis_tdata = '0;   // address[32]
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;        // hit, way[3], replaced_valid,
                                                 // cycle_total[32], miss_total[32]

    lookup_scoreboard sb;
    logic [15:0]      dir_cfg [CFG_INDEX_BITS:CFG_POLICY];
    logic [31:0]      dir_addrs [$];
    int               burst_left = 0;
    bit               gaps_on = 1'b1;
    rx_pace_t         rx_pace = RX_ALWAYS;
    int unsigned      pace_count = 0;
    int               quiet_cycles = 0;

    set_assoc_cache_lru_lfu dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    // Transaction monitors feed the scoreboard
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_lookup(s_axis_tdata[31:0]);
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    // Result backpressure with a randomly switching pattern
    always @(posedge clk)
    begin
        pace_count <= pace_count + 1;
        if (pace_count[6:0] == 7'd0)
            rx_pace <= rx_pace_t'($urandom_range(RX_ALWAYS, RX_SPARSE));
        case (rx_pace)
            RX_ALWAYS:   m_axis_tready <= 1'b1;
            RX_RANDOM:   m_axis_tready <= ($urandom_range(0, 3) != 0);
            RX_PERIODIC: m_axis_tready <= ((pace_count % 5) < 2);
            default:     m_axis_tready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    // Watchdog on cycles with no transaction on either stream
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("set_assoc_cache_lru_lfu test failed");
            $finish;
        end
    end

    // Write every register from dir_cfg, then poke the unmapped index
    task automatic program_directory();
        for (int i = CFG_INDEX_BITS; i <= CFG_POLICY; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_addr  <= i[CFG_ADDR_W-1:0];
            cfg_wdata <= dir_cfg[i];
            sb.write_reg(i[CFG_ADDR_W-1:0], dir_cfg[i]);
            @(posedge clk);
        end
        cfg_addr  <= CFG_NO_REG;
        cfg_wdata <= 16'($urandom);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Present one address, with bursts and random gaps between them
    task automatic send_address(logic [31:0] addr);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = gaps_on ? $urandom_range(0, 6) : 0;
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= addr;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        burst_left--;
    endtask

    task automatic send_list();
        foreach (dir_addrs[i])
            send_address(dir_addrs[i]);
    endtask

    // Stop sending and let every outstanding lookup come back
    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        // let the monitor note the last accepted address first
        @(posedge clk);
        while (sb.pending_lookups.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Build an address with a chosen set index and random block offset
    function automatic logic [31:0] place_addr(logic [31:0] base, logic [31:0] set_sel,
                                               logic [31:0] off, int ib, int ob);
        logic [63:0] a, s, o, imask, omask;
        a     = {32'b0, base};
        s     = {32'b0, set_sel};
        o     = {32'b0, off};
        omask = (64'd1 << ob) - 64'd1;
        imask = ((64'd1 << ib) - 64'd1) << ob;
        a     = (a & ~imask & ~omask) | ((s << ob) & imask) | (o & omask);
        return a[31:0];
    endfunction

    // One random configuration, then traffic over a small pool of lines
    task automatic random_phase(int phase_no);
        logic [31:0] pool [$];
        logic [31:0] set_pick [2];
        logic [31:0] a;
        int          ib, nw;

        dir_cfg[CFG_INDEX_BITS]  = ($urandom_range(0, 5) == 0) ? 16'($urandom_range(0, 15))
                                                               : 16'($urandom_range(0, 3));
        dir_cfg[CFG_OFFSET_BITS] = ($urandom_range(0, 5) == 0) ? 16'($urandom_range(0, 31))
                                                               : 16'($urandom_range(0, 6));
        dir_cfg[CFG_ADDR_BITS]   = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 63))
                                                               : 16'd32;
        dir_cfg[CFG_WAYS_USED]   = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 15))
                                                               : 16'($urandom_range(1, 8));
        dir_cfg[CFG_HIT_CYCLES]  = 16'($urandom_range(0, 65535));
        dir_cfg[CFG_MISS_EXTRA]  = ($urandom_range(0, 5) == 0) ? 16'd0
                                                               : 16'($urandom_range(0, 65535));
        dir_cfg[CFG_POLICY]      = 16'(phase_no % 2);
        program_directory();

        ib = (dir_cfg[CFG_INDEX_BITS] > DEF_MAX_INDEX_BITS) ? DEF_MAX_INDEX_BITS
                                                            : int'(dir_cfg[CFG_INDEX_BITS]);
        nw = (dir_cfg[CFG_WAYS_USED] == 0) ? 1 : int'(dir_cfg[CFG_WAYS_USED]);
        set_pick[0] = $urandom;
        set_pick[1] = $urandom;
        for (int i = 0; i < nw + 2; i++)
            pool.push_back($urandom);
        gaps_on = (phase_no != 1);

        for (int n = 0; n < PHASE_ITEMS; n++)
        begin
            // hold off once mid-phase until the block has caught up
            if (n == PHASE_ITEMS / 2)
                wait_drain();
            if ($urandom_range(0, 99) < 15)
                a = $urandom;
            else
                a = place_addr(pool[$urandom_range(0, pool.size() - 1)],
                               set_pick[$urandom_range(0, 1)], $urandom, ib,
                               int'(dir_cfg[CFG_OFFSET_BITS]));
            send_address(a);
        end
        wait_drain();
    endtask

    initial
    begin
        sb = new();
        dir_cfg[CFG_INDEX_BITS]  = 16'd0;
        dir_cfg[CFG_OFFSET_BITS] = 16'd0;
        dir_cfg[CFG_ADDR_BITS]   = 16'd32;
        dir_cfg[CFG_WAYS_USED]   = 16'd1;
        dir_cfg[CFG_HIT_CYCLES]  = 16'd1;
        dir_cfg[CFG_MISS_EXTRA]  = 16'd0;
        dir_cfg[CFG_POLICY]      = 16'd0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: one direct-mapped line, extreme addresses
        dir_addrs = '{32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
        send_list();
        wait_drain();

        // Four ways under LRU: fill a set, hit, then evict the oldest
        dir_cfg[CFG_INDEX_BITS]  = 16'd1;
        dir_cfg[CFG_OFFSET_BITS] = 16'd4;
        dir_cfg[CFG_ADDR_BITS]   = 16'd16;
        dir_cfg[CFG_WAYS_USED]   = 16'd4;
        dir_cfg[CFG_HIT_CYCLES]  = 16'd3;
        dir_cfg[CFG_MISS_EXTRA]  = 16'd100;
        program_directory();
        dir_addrs = '{32'h0000_0000, 32'h0000_0020, 32'h0000_0040, 32'h0000_0060,
                      32'h0000_000F, 32'h0000_0080, 32'hFFFF_0020};
        send_list();
        wait_drain();

        // Switch to LFU with the old stamps in place; equal counts go to lowest way
        dir_cfg[CFG_POLICY] = 16'd1;
        program_directory();
        dir_addrs = '{32'h0000_0000, 32'h0000_0000, 32'h0000_0020, 32'h0000_00A0,
                      32'h0000_0040};
        send_list();
        wait_drain();

        // Oversized fields saturate; offset plus index past the address leaves no tag
        dir_cfg[CFG_INDEX_BITS]  = 16'hFFFF;
        dir_cfg[CFG_OFFSET_BITS] = 16'd31;
        dir_cfg[CFG_ADDR_BITS]   = 16'd63;
        dir_cfg[CFG_WAYS_USED]   = 16'd0;
        dir_cfg[CFG_HIT_CYCLES]  = 16'hFFFF;
        dir_cfg[CFG_MISS_EXTRA]  = 16'hFFFF;
        dir_cfg[CFG_POLICY]      = 16'd0;
        program_directory();
        dir_addrs = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF};
        send_list();
        wait_drain();

        // One-bit address, full index, way count above the maximum, free accesses
        dir_cfg[CFG_INDEX_BITS]  = 16'd8;
        dir_cfg[CFG_OFFSET_BITS] = 16'd0;
        dir_cfg[CFG_ADDR_BITS]   = 16'd1;
        dir_cfg[CFG_WAYS_USED]   = 16'd15;
        dir_cfg[CFG_HIT_CYCLES]  = 16'd0;
        dir_cfg[CFG_MISS_EXTRA]  = 16'd0;
        dir_cfg[CFG_POLICY]      = 16'd1;
        program_directory();
        dir_addrs = '{32'h0000_0000, 32'h0000_0100, 32'hFFFF_FFFF};
        send_list();
        wait_drain();

        for (int p = 0; p < RANDOM_PHASES; p++)
            random_phase(p);

        repeat (8) @(posedge clk);
        if (sb.failures == 0 && sb.pending_lookups.size() == 0)
            $display("set_assoc_cache_lru_lfu test passed");
        else
            $display("set_assoc_cache_lru_lfu test failed");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hdl
hdl/sacl_pkg.sv
hdl/sacl_ram.sv
hdl/set_assoc_cache_lru_lfu.sv
verif/tb.sv
